FILE: rtl/core/iplpm_pkg.sv
// shared types and constants of the longest prefix match rule table
// no dependencies; used by the interfaces, the match unit and the top level
`default_nettype none

package iplpm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int POLICY_BITS = 16;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W = 128;
    localparam int HALF_W = 64;
    localparam int LEN_W  = 8;
    localparam int POL_W  = 16;
    localparam int STS_W  = 2;

    localparam logic [LEN_W-1:0] V4_MAX_LEN = 8'd32;
    localparam logic [LEN_W-1:0] V6_MAX_LEN = 8'd128;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;
    localparam logic FAM_V4      = 1'b0;
    localparam logic FAM_V6      = 1'b1;

    typedef logic [POLICY_BITS-1:0] t_policy;
    typedef logic [POL_W-1:0]       t_pol_out;
    typedef logic [LEN_W-1:0]       t_len;
    typedef logic [IDX_W-1:0]       t_idx;
    typedef logic [CNT_W-1:0]       t_cnt;

    typedef enum logic [STS_W-1:0] {
        STS_DONE       = 2'd0,
        STS_BAD_PREFIX = 2'd1,
        STS_FULL       = 2'd2
    } t_status;

    typedef struct packed {
        logic              family;
        logic [HALF_W-1:0] net_hi;
        logic [HALF_W-1:0] net_lo;
        t_len              len;
        t_policy           policy;
    } t_rule;

    localparam int RULE_W = $bits(t_rule);

endpackage

`default_nettype wire

FILE: rtl/core/iplpm_if.sv
// request and response channel interfaces of the prefix match table
// depends on iplpm_pkg
`default_nettype none

interface iplpm_req_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic                       family;
    logic [iplpm_pkg::HALF_W-1:0] addr_hi;
    logic [iplpm_pkg::HALF_W-1:0] addr_lo;
    logic [iplpm_pkg::LEN_W-1:0]  prefix_len;
    logic [iplpm_pkg::POL_W-1:0]  policy_in;

    modport source (output valid, mode, family, addr_hi, addr_lo, prefix_len, policy_in,
                    input ready);
    modport sink   (input valid, mode, family, addr_hi, addr_lo, prefix_len, policy_in,
                    output ready);
endinterface

interface iplpm_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        hit;
    logic [iplpm_pkg::POL_W-1:0] policy_out;
    logic [iplpm_pkg::LEN_W-1:0] matched_len;
    logic [iplpm_pkg::STS_W-1:0] status;

    modport source (output valid, hit, policy_out, matched_len, status, input ready);
    modport sink   (input valid, hit, policy_out, matched_len, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/iplpm_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`default_nettype none

module iplpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                              i_wr_data,
    input  wire logic                                          i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                              o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/iplpm_match.sv
// prefix compare unit: tests the leading len bits of an address against a rule network
// depends on iplpm_pkg
`default_nettype none

module iplpm_match (
    input  wire logic [iplpm_pkg::ADDR_W-1:0] i_addr,
    input  wire logic [iplpm_pkg::ADDR_W-1:0] i_net,
    input  wire iplpm_pkg::t_len              i_len,
    output logic                              o_match
);

    logic [iplpm_pkg::ADDR_W-1:0] mask;

    // bit k from the top is compared when k is below the prefix length
    always_comb begin
        for (int k = 0; k < iplpm_pkg::ADDR_W; k++) begin
            mask[iplpm_pkg::ADDR_W-1-k] = (iplpm_pkg::LEN_W'(k) < i_len);
        end
    end

    assign o_match = ((i_addr ^ i_net) & mask) == '0;

endmodule

`default_nettype wire

FILE: rtl/core/ip_longest_prefix_match_table_unit.sv
// top level of the longest prefix match rule table
// depends on iplpm_pkg, iplpm_if, iplpm_ram and iplpm_match
//
//   port     dir  kind          carries
//   i_req    in   valid/ready   mode, family, addr_hi, addr_lo, prefix_len, policy_in
//   o_rsp    out  valid/ready   hit, policy_out, matched_len, status
//
// an insert is checked and written into the rule ram in its transfer cycle; the
// result is registered in r_status and passes through ST_DONE to the output registers
// a lookup reads one stored rule per cycle from the rule ram through the shared
// compare unit in ST_SCAN; its result then passes through ST_DONE to the output registers
// one item at a time; a result waiting on o_rsp holds the next item in ST_DONE
// synchronous active-low reset empties the table, no clearing pass
`default_nettype none

module ip_longest_prefix_match_table_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    iplpm_req_if.sink   i_req,
    iplpm_rsp_if.source o_rsp
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    iplpm_pkg::t_cnt r_count, n_count;
    iplpm_pkg::t_idx r_idx, n_idx;
    logic r_out_valid, n_out_valid;

    logic                         r_fam, n_fam;
    logic [iplpm_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic                         r_hit, n_hit;
    iplpm_pkg::t_len              r_best_len, n_best_len;
    iplpm_pkg::t_policy           r_best_pol, n_best_pol;
    iplpm_pkg::t_status           r_status, n_status;

    logic                  r_o_hit, n_o_hit;
    iplpm_pkg::t_pol_out   r_o_pol, n_o_pol;
    iplpm_pkg::t_len       r_o_len, n_o_len;
    iplpm_pkg::t_status    r_o_status, n_o_status;

    logic                           wr_en;
    iplpm_pkg::t_rule               wr_rule;
    logic                           rd_en;
    iplpm_pkg::t_idx                rd_addr;
    logic [iplpm_pkg::RULE_W-1:0]   rd_data;
    iplpm_pkg::t_rule               rd_rule;
    logic                           rule_match;
    logic                           req_xfer;
    logic                           bad_prefix;
    logic                           full;
    logic                           last;

    iplpm_ram #(
        .WIDTH (iplpm_pkg::RULE_W),
        .DEPTH (iplpm_pkg::TABLE_DEPTH)
    ) u_rule_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[iplpm_pkg::IDX_W-1:0]),
        .i_wr_data (wr_rule),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_rule = rd_data;

    iplpm_match u_match (
        .i_addr  (r_addr),
        .i_net   ({rd_rule.net_hi, rd_rule.net_lo}),
        .i_len   (rd_rule.len),
        .o_match (rule_match)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign req_xfer    = i_req.valid && i_req.ready;

    assign bad_prefix = (i_req.family == iplpm_pkg::FAM_V4) ?
                        (i_req.prefix_len > iplpm_pkg::V4_MAX_LEN) :
                        (i_req.prefix_len > iplpm_pkg::V6_MAX_LEN);
    assign full = (r_count == iplpm_pkg::CNT_W'(iplpm_pkg::TABLE_DEPTH));
    assign last = (iplpm_pkg::CNT_W'(r_idx) == (r_count - iplpm_pkg::CNT_W'(1)));

    always_comb begin
        wr_rule.family = i_req.family;
        wr_rule.net_hi = i_req.addr_hi;
        wr_rule.net_lo = i_req.addr_lo;
        wr_rule.len    = i_req.prefix_len;
        wr_rule.policy = iplpm_pkg::t_policy'(i_req.policy_in);
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_fam       = r_fam;
        n_addr      = r_addr;
        n_hit       = r_hit;
        n_best_len  = r_best_len;
        n_best_pol  = r_best_pol;
        n_status    = r_status;
        n_o_hit     = r_o_hit;
        n_o_pol     = r_o_pol;
        n_o_len     = r_o_len;
        n_o_status  = r_o_status;
        n_out_valid = r_out_valid && !o_rsp.ready;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (req_xfer) begin
                    n_fam      = i_req.family;
                    n_addr     = {i_req.addr_hi, i_req.addr_lo};
                    n_hit      = 1'b0;
                    n_best_len = '0;
                    n_best_pol = '0;
                    n_status   = iplpm_pkg::STS_DONE;
                    n_idx      = '0;
                    if (i_req.mode == iplpm_pkg::MODE_INSERT) begin
                        n_state = ST_DONE;
                        if (bad_prefix) begin
                            n_status = iplpm_pkg::STS_BAD_PREFIX;
                        end else if (full) begin
                            n_status = iplpm_pkg::STS_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + iplpm_pkg::CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        // first rule read issued in the transfer cycle
                        rd_en   = 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // later rules win ties, hence the greater-or-equal test
                if ((rd_rule.family == r_fam) && rule_match &&
                    (!r_hit || (rd_rule.len >= r_best_len))) begin
                    n_hit      = 1'b1;
                    n_best_len = rd_rule.len;
                    n_best_pol = rd_rule.policy;
                end
                if (last) begin
                    n_state = ST_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + iplpm_pkg::IDX_W'(1);
                    n_idx   = r_idx + iplpm_pkg::IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid = 1'b1;
                    n_o_hit     = r_hit;
                    n_o_pol     = iplpm_pkg::t_pol_out'(r_best_pol);
                    n_o_len     = r_best_len;
                    n_o_status  = r_status;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_fam      <= n_fam;
        r_addr     <= n_addr;
        r_hit      <= n_hit;
        r_best_len <= n_best_len;
        r_best_pol <= n_best_pol;
        r_status   <= n_status;
        r_o_hit    <= n_o_hit;
        r_o_pol    <= n_o_pol;
        r_o_len    <= n_o_len;
        r_o_status <= n_o_status;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_o_hit;
    assign o_rsp.policy_out  = r_o_pol;
    assign o_rsp.matched_len = r_o_len;
    assign o_rsp.status      = r_o_status;

endmodule

`default_nettype wire
